@@ rtl/fanidx_pkg.sv @@
// Shared types and constants for the geomipmap fan index generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fanidx_pkg;

	// Vertex index width; all index arithmetic wraps at this width
	localparam int IDX_W = 22;
	// Register widths and config port
	localparam int STRIDE_W = 14;
	localparam int PSIZE_W = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 14;
	// Step width: up to 2^(lod+1) with the widest neighbour lod
	localparam int STEP_W = 9;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIZE = 1'd1;

	// Reset values
	localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 14'd257;
	localparam logic [PSIZE_W-1:0] PATCH_SIZE_RST = 9'd33;

	// Fan sides in walk order
	localparam logic [1:0] SIDE_LEFT = 2'd0;
	localparam logic [1:0] SIDE_TOP = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;
	localparam logic [1:0] SIDE_BOTTOM = 2'd3;

	// Depth of the queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] fan_x;
		logic [7:0] fan_z;
		logic [2:0] lod_core;
		logic [3:0] lod_left;
		logic [3:0] lod_right;
		logic [3:0] lod_top;
		logic [3:0] lod_bottom;
	} fanidx_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_center;
		logic [IDX_W-1:0] vertex_first;
		logic [IDX_W-1:0] vertex_second;
		logic last_triangle;
	} fanidx_result_t;

	// One classified fan: start vertices, per-side signed step and two-triangle flags
	typedef struct packed {
		logic [IDX_W-1:0] center;
		logic [IDX_W-1:0] first_a;
		logic [IDX_W-1:0] first_b;
		logic [3:0][IDX_W-1:0] delta;
		logic [3:0] two_tri;
	} fanidx_entry_t;

endpackage

`default_nettype wire

@@ rtl/geomip_fan_index_generator_core.sv @@
// Top level of the geomipmap fan index generator: config registers, front, queue, back.
// Depends on fanidx_pkg, fanidx_front, fanidx_queue, fanidx_back.
`timescale 1ns / 1ps
`default_nettype none

// A fan is taken when start is high and busy low. It yields 4 to 8 triangle beats,
// one per cycle on result_valid; the receiver cannot stall, so every beat must be
// taken as it comes. The back walker emits one triangle per cycle, and queued fans
// follow each other with no gap between their beats. A fan taken while the walker
// is idle passes the two front stages, the queue, the walker state and the result
// register before its first beat. busy rises once the two front stages and the
// four-entry queue hold as many fans as the queue can absorb. The user must write
// row_stride and patch_size only while the block is idle; the block does not enforce it.
module geomip_fan_index_generator_core
	import fanidx_pkg::*;
#(
	parameter int MAX_ROW_STRIDE = 8192,
	parameter int MAX_LOD = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire fanidx_item_t          item,
	output      logic                  result_valid,
	output      fanidx_result_t        result,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WMAX_I = (MAX_ROW_STRIDE > 16383) ? 16383 : MAX_ROW_STRIDE;
	localparam logic [STRIDE_W-1:0] WMAX = STRIDE_W'(WMAX_I);

	logic [STRIDE_W-1:0] row_stride_q;
	logic [PSIZE_W-1:0] patch_size_q;
	logic [STRIDE_W-1:0] stride;
	logic accept;
	logic push, pop, not_empty;
	fanidx_entry_t push_data, head;
	logic [1:0] in_flight;
	logic [QCNT_W-1:0] count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q <= ROW_STRIDE_RST;
			patch_size_q <= PATCH_SIZE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_STRIDE: row_stride_q <= cfg_data[STRIDE_W-1:0];
				REG_PATCH_SIZE: patch_size_q <= cfg_data[PSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stride clamp and credit check against queue room
	always_comb begin
		stride = (row_stride_q > WMAX) ? WMAX : row_stride_q;
		busy = (5'(count) + 5'(in_flight)) >= 5'(QDEPTH);
		accept = start && !busy;
	end

	fanidx_front #(
		.MAX_LOD(MAX_LOD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.stride    (stride),
		.patch_size(patch_size_q),
		.push      (push),
		.push_data (push_data),
		.in_flight (in_flight)
	);

	fanidx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.count    (count)
	);

	fanidx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

`default_nettype wire

@@ rtl/fanidx_front.sv @@
// Front end: classifies each fan (edge levels, steps) and forms start indices.
// Depends on fanidx_pkg. Two register stages, the multipliers sit in stage 2.
`timescale 1ns / 1ps
`default_nettype none

module fanidx_front
	import fanidx_pkg::*;
#(
	parameter int MAX_LOD = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire fanidx_item_t        item,
	input  wire logic [STRIDE_W-1:0] stride,
	input  wire logic [PSIZE_W-1:0]  patch_size,
	output      logic                push,
	output      fanidx_entry_t       push_data,
	output      logic [1:0]          in_flight
);

	localparam logic [2:0] LC_MAX = 3'(MAX_LOD);
	localparam logic [3:0] NL_MAX = 4'(MAX_LOD + 1);

	logic [2:0] lc;
	logic [3:0] nl, nr, nt, nb;
	logic [3:0] el, er, et, eb;
	logic signed [10:0] end_pos;
	logic on_right, on_top;

	// Stage 1 registers
	logic v_s1;
	logic [7:0] x_s1, z_s1, sc_s1;
	logic [STEP_W-1:0] sl_s1, st_s1, sr_s1, sb_s1;
	logic [3:0] two_s1;
	logic [STRIDE_W-1:0] w_s1;

	// Stage 2 registers
	logic v_s2;
	logic [7:0] x_s2, sc_s2;
	logic [IDX_W-1:0] zw_s2, zcw_s2, slw_s2, srw_s2;
	logic [STEP_W-1:0] st_s2, sb_s2;
	logic [3:0] two_s2;

	// Saturate levels and pick per-side edge level from the border test
	always_comb begin
		lc = (item.lod_core > LC_MAX) ? LC_MAX : item.lod_core;
		nl = (item.lod_left > NL_MAX) ? NL_MAX : item.lod_left;
		nr = (item.lod_right > NL_MAX) ? NL_MAX : item.lod_right;
		nt = (item.lod_top > NL_MAX) ? NL_MAX : item.lod_top;
		nb = (item.lod_bottom > NL_MAX) ? NL_MAX : item.lod_bottom;
		end_pos = $signed({2'b00, patch_size}) - 11'sd1
			- $signed(11'(11'd1 << ({1'b0, lc} + 4'd1)));
		on_right = !end_pos[10] && (end_pos[9:0] == {2'b00, item.fan_x});
		on_top = !end_pos[10] && (end_pos[9:0] == {2'b00, item.fan_z});
		el = (item.fan_x == 8'd0) ? nl : {1'b0, lc};
		er = on_right ? nr : {1'b0, lc};
		eb = (item.fan_z == 8'd0) ? nb : {1'b0, lc};
		et = on_top ? nt : {1'b0, lc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: steps and flags
	always_ff @(posedge clk) begin
		x_s1 <= item.fan_x;
		z_s1 <= item.fan_z;
		sc_s1 <= 8'(8'd1 << lc);
		sl_s1 <= STEP_W'(9'd1 << el);
		st_s1 <= STEP_W'(9'd1 << et);
		sr_s1 <= STEP_W'(9'd1 << er);
		sb_s1 <= STEP_W'(9'd1 << eb);
		two_s1[SIDE_LEFT] <= (el == {1'b0, lc});
		two_s1[SIDE_TOP] <= (et == {1'b0, lc});
		two_s1[SIDE_RIGHT] <= (er == {1'b0, lc});
		two_s1[SIDE_BOTTOM] <= (eb == {1'b0, lc});
		w_s1 <= stride;
	end

	// Stage 2: row products
	always_ff @(posedge clk) begin
		x_s2 <= x_s1;
		sc_s2 <= sc_s1;
		zw_s2 <= IDX_W'({9'd0, z_s1} * {3'd0, w_s1});
		zcw_s2 <= IDX_W'(({1'b0, z_s1} + {1'b0, sc_s1}) * {3'd0, w_s1});
		slw_s2 <= IDX_W'({8'd0, sl_s1} * {3'd0, w_s1});
		srw_s2 <= IDX_W'({8'd0, sr_s1} * {3'd0, w_s1});
		st_s2 <= st_s1;
		sb_s2 <= sb_s1;
		two_s2 <= two_s1;
	end

	// Queue entry: start vertices and signed per-side steps
	always_comb begin
		push = v_s2;
		push_data.center = zcw_s2 + IDX_W'(x_s2) + IDX_W'(sc_s2);
		push_data.first_a = zw_s2 + IDX_W'(x_s2);
		push_data.first_b = zw_s2 + IDX_W'(x_s2) + slw_s2;
		push_data.delta[SIDE_LEFT] = slw_s2;
		push_data.delta[SIDE_TOP] = IDX_W'(st_s2);
		push_data.delta[SIDE_RIGHT] = IDX_W'(0) - srw_s2;
		push_data.delta[SIDE_BOTTOM] = IDX_W'(0) - IDX_W'(sb_s2);
		push_data.two_tri = two_s2;
		in_flight = {1'b0, v_s1} + {1'b0, v_s2};
	end

endmodule

`default_nettype wire

@@ rtl/fanidx_queue.sv @@
// Short FIFO of classified fans between front and back.
// Depends on fanidx_pkg. Flip-flop storage, combinational head read.
`timescale 1ns / 1ps
`default_nettype none

module fanidx_queue
	import fanidx_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire fanidx_entry_t     push_data,
	input  wire logic              pop,
	output      fanidx_entry_t     head,
	output      logic              not_empty,
	output      logic [QCNT_W-1:0] count
);

	fanidx_entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count = count_q;

	// Credits upstream must keep the queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q != QCNT_W'(QDEPTH))
		else $error("fanidx_queue: push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("fanidx_queue: pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/fanidx_back.sv @@
// Back end: walks the fan perimeter into the result register, one triangle per cycle
// while a fan is active. Depends on fanidx_pkg. Pulls classified fans from fanidx_queue.
`timescale 1ns / 1ps
`default_nettype none

module fanidx_back
	import fanidx_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire fanidx_entry_t  head,
	input  wire logic           not_empty,
	output      logic           pop,
	output      logic           result_valid,
	output      fanidx_result_t result
);

	logic active_q;
	logic [IDX_W-1:0] center_q, a_q, b_q;
	logic [3:0][IDX_W-1:0] delta_q;
	logic [3:0] two_q;
	logic [1:0] side_q;
	logic second_q;
	logic valid_q;
	fanidx_result_t result_q;

	logic last, stay;
	logic [1:0] nside;

	// Next step of the walk
	always_comb begin
		last = (side_q == SIDE_BOTTOM) && (second_q || !two_q[SIDE_BOTTOM]);
		stay = !second_q && two_q[side_q];
		nside = stay ? side_q : side_q + 2'd1;
		pop = not_empty && (!active_q || last);
	end

	// Walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q <= 1'b0;
			side_q <= SIDE_LEFT;
			second_q <= 1'b0;
		end else begin
			valid_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				side_q <= SIDE_LEFT;
				second_q <= 1'b0;
			end else if (active_q && last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				side_q <= nside;
				second_q <= stay;
			end
		end
	end

	// Walker datapath and result register
	always_ff @(posedge clk) begin
		result_q.vertex_center <= center_q;
		result_q.vertex_first <= a_q;
		result_q.vertex_second <= b_q;
		result_q.last_triangle <= last;
		if (pop) begin
			center_q <= head.center;
			a_q <= head.first_a;
			b_q <= head.first_b;
			delta_q <= head.delta;
			two_q <= head.two_tri;
		end else if (active_q) begin
			a_q <= b_q;
			b_q <= b_q + delta_q[nside];
		end
	end

	assign result_valid = valid_q;
	assign result = result_q;

	// Every active cycle yields exactly one beat
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |=> result_valid)
		else $error("fanidx_back: active cycle without result beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |=> !result_valid)
		else $error("fanidx_back: result beat while idle");
	// A second triangle only on a side that keeps both
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q && second_q |-> two_q[side_q])
		else $error("fanidx_back: second triangle on a stitched side");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for geomip_fan_index_generator_core: fan cells in, triangle beats out.
// Depends on fanidx_pkg and the RTL under rtl/; predicts every fan and checks each beat in order.
`timescale 1ns / 1ps

module testbench;
	import fanidx_pkg::*;

	localparam int STRIDE_CAP = 8192;
	localparam int LOD_CAP = 7;
	localparam int DRAIN_CYCLES = 12;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam int PRINT_CAP = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	fanidx_item_t item = '0;
	logic result_valid;
	fanidx_result_t result;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies seen by the predictor
	logic [STRIDE_W-1:0] grid_stride = ROW_STRIDE_RST;
	logic [PSIZE_W-1:0] patch_edge = PATCH_SIZE_RST;

	// Triangles still owed by the block, oldest first
	fanidx_result_t pending_tris[$];
	int mismatches = 0;

	geomip_fan_index_generator_core #(
		.MAX_ROW_STRIDE(STRIDE_CAP),
		.MAX_LOD(LOD_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Walk the fan perimeter and queue the triangles it yields
	function automatic void predict_fan(input fanidx_item_t it);
		bit [63:0] col, row, w, ctr, b;
		bit [63:0] delta[4];
		bit [3:0] nbr[4];
		bit [3:0] side_lod[4];
		bit [3:0] lc;
		int end_pos, s, k;
		fanidx_result_t beat;
		fanidx_result_t fan[$];
		col = it.fan_x;
		row = it.fan_z;
		lc = (it.lod_core > LOD_CAP) ? 4'(LOD_CAP) : 4'(it.lod_core);
		nbr[SIDE_LEFT] = it.lod_left;
		nbr[SIDE_TOP] = it.lod_top;
		nbr[SIDE_RIGHT] = it.lod_right;
		nbr[SIDE_BOTTOM] = it.lod_bottom;
		for (s = 0; s < 4; s++)
			if (nbr[s] > LOD_CAP + 1)
				nbr[s] = 4'(LOD_CAP + 1);
		w = (grid_stride > STRIDE_CAP) ? 64'(STRIDE_CAP) : 64'(grid_stride);
		end_pos = int'(patch_edge) - 1 - (1 << (lc + 1));

		// Border sides take the neighbour level, all others the core level
		side_lod[SIDE_LEFT] = (col == 0) ? nbr[SIDE_LEFT] : lc;
		side_lod[SIDE_RIGHT] = (end_pos >= 0 && int'(col) == end_pos) ? nbr[SIDE_RIGHT] : lc;
		side_lod[SIDE_BOTTOM] = (row == 0) ? nbr[SIDE_BOTTOM] : lc;
		side_lod[SIDE_TOP] = (end_pos >= 0 && int'(row) == end_pos) ? nbr[SIDE_TOP] : lc;

		delta[SIDE_LEFT] = (64'd1 << side_lod[SIDE_LEFT]) * w;
		delta[SIDE_TOP] = 64'd1 << side_lod[SIDE_TOP];
		delta[SIDE_RIGHT] = -((64'd1 << side_lod[SIDE_RIGHT]) * w);
		delta[SIDE_BOTTOM] = -(64'd1 << side_lod[SIDE_BOTTOM]);

		ctr = (row + (64'd1 << lc)) * w + col + (64'd1 << lc);
		b = row * w + col;
		// A stitched side keeps only its first triangle
		for (s = SIDE_LEFT; s <= SIDE_BOTTOM; s++) begin
			for (k = 0; k < 2; k++) begin
				if (k == 0 || side_lod[s] == lc) begin
					beat.vertex_center = ctr[IDX_W-1:0];
					beat.vertex_first = b[IDX_W-1:0];
					b = b + delta[s];
					beat.vertex_second = b[IDX_W-1:0];
					beat.last_triangle = 1'b0;
					fan.push_back(beat);
				end
			end
		end
		fan[fan.size() - 1].last_triangle = 1'b1;
		foreach (fan[i])
			pending_tris.push_back(fan[i]);
	endfunction

	// Check every beat against the oldest pending triangle
	always @(posedge clk) begin : check_beats
		fanidx_result_t want;
		if (arst_n && result_valid !== 1'b0) begin
			if (pending_tris.size() == 0) begin
				report_mismatch("beat with no fan pending", result.vertex_center, 0);
			end else begin
				want = pending_tris.pop_front();
				if (result.vertex_center !== want.vertex_center)
					report_mismatch("vertex_center", result.vertex_center, want.vertex_center);
				if (result.vertex_first !== want.vertex_first)
					report_mismatch("vertex_first", result.vertex_first, want.vertex_first);
				if (result.vertex_second !== want.vertex_second)
					report_mismatch("vertex_second", result.vertex_second, want.vertex_second);
				if (result.last_triangle !== want.last_triangle)
					report_mismatch("last_triangle", result.last_triangle, want.last_triangle);
			end
		end
	end

	// Hold the fan on the bus until it is taken; start stays high for the caller
	task automatic send_fan(input fanidx_item_t it);
		item <= it;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_fan(it);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Let every owed triangle arrive, then let the pipeline settle
	task automatic wait_drain();
		start <= 1'b0;
		while (pending_tris.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_ROW_STRIDE: grid_stride = val[STRIDE_W-1:0];
			REG_PATCH_SIZE: patch_edge = val[PSIZE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] stride,
			input logic [CFG_DATA_W-1:0] psize);
		wait_drain();
		write_reg(REG_ROW_STRIDE, stride);
		write_reg(REG_PATCH_SIZE, psize);
	endtask

	function automatic fanidx_item_t mk_fan(input int x, input int z, input int lc,
			input int l, input int r, input int t, input int bt);
		fanidx_item_t it;
		it.fan_x = 8'(x);
		it.fan_z = 8'(z);
		it.lod_core = 3'(lc);
		it.lod_left = 4'(l);
		it.lod_right = 4'(r);
		it.lod_top = 4'(t);
		it.lod_bottom = 4'(bt);
		return it;
	endfunction

	// Neighbour level: mostly near the core level, sometimes anything the field holds
	function automatic logic [3:0] near_lod(input int lc);
		case ($urandom_range(0, 5))
			0, 1: return 4'(lc);
			2: return 4'(lc + 1);
			3: return (lc > 0) ? 4'(lc - 1) : 4'd0;
			default: return 4'($urandom_range(0, 15));
		endcase
	endfunction

	// Mostly aligned cells of a well-formed patch, border cells favored; the rest is noise
	function automatic fanidx_item_t random_fan();
		fanidx_item_t it;
		int span, max_lc, lc, cells, pick_x, pick_z;
		span = int'(patch_edge) - 1;
		if ($urandom_range(0, 9) < 3 || span < 2 || (span & (span - 1)) != 0) begin
			it.fan_x = 8'($urandom_range(0, 255));
			it.fan_z = 8'($urandom_range(0, 255));
			it.lod_core = 3'($urandom_range(0, 7));
			it.lod_left = 4'($urandom_range(0, 15));
			it.lod_right = 4'($urandom_range(0, 15));
			it.lod_top = 4'($urandom_range(0, 15));
			it.lod_bottom = 4'($urandom_range(0, 15));
			return it;
		end
		max_lc = $clog2(span) - 1;
		if (max_lc > LOD_CAP)
			max_lc = LOD_CAP;
		lc = $urandom_range(0, max_lc);
		cells = span >> (lc + 1);
		pick_x = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? cells - 1
				: $urandom_range(0, cells - 1));
		pick_z = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? cells - 1
				: $urandom_range(0, cells - 1));
		it.fan_x = 8'(pick_x << (lc + 1));
		it.fan_z = 8'(pick_z << (lc + 1));
		it.lod_core = 3'(lc);
		it.lod_left = near_lod(lc);
		it.lod_right = near_lod(lc);
		it.lod_top = near_lod(lc);
		it.lod_bottom = near_lod(lc);
		return it;
	endfunction

	// Reset-default registers: corners, interior, stitching per side, oversized levels
	task automatic test_corner_cells();
		send_fan(mk_fan(0, 0, 0, 0, 0, 0, 0));
		send_fan(mk_fan(0, 0, 0, 1, 1, 1, 1));
		send_fan(mk_fan(30, 30, 0, 0, 1, 1, 0));
		send_fan(mk_fan(16, 16, 3, 4, 4, 4, 4));
		send_fan(mk_fan(4, 8, 1, 3, 5, 7, 2));
		send_fan(mk_fan(0, 0, 2, 15, 3, 3, 9));
		send_fan(mk_fan(30, 0, 0, 0, 8, 0, 8));
		send_fan(mk_fan(3, 5, 2, 0, 0, 0, 0));
		send_fan(mk_fan(0, 0, 7, 8, 8, 8, 8));
		send_fan(mk_fan(255, 255, 7, 15, 15, 15, 15));
		pause_sender(1);
	endtask

	// Register extremes: stride saturation, masked patch data, tiny and largest patches
	task automatic test_config_extremes();
		set_config(14'h3FFF, 14'd257);
		send_fan(mk_fan(0, 0, 7, 6, 8, 6, 8));
		send_fan(mk_fan(254, 254, 0, 1, 1, 1, 1));
		send_fan(mk_fan(128, 64, 6, 0, 0, 0, 0));
		set_config(14'd2, {5'h1F, 9'd3});
		send_fan(mk_fan(0, 0, 0, 1, 2, 3, 0));
		send_fan(mk_fan(0, 0, 1, 2, 2, 2, 2));
		set_config(14'd0, 14'd0);
		send_fan(mk_fan(5, 9, 2, 1, 1, 1, 1));
		send_fan(mk_fan(0, 0, 0, 8, 8, 8, 8));
		set_config(14'd8192, 14'd511);
		send_fan(mk_fan(0, 254, 7, 8, 8, 8, 8));
		send_fan(mk_fan(254, 0, 0, 3, 3, 3, 3));
	endtask

	// Random fans in bursts over several register settings
	task automatic test_random_fans();
		logic [CFG_DATA_W-1:0] strides[6];
		logic [CFG_DATA_W-1:0] psizes[6];
		int burst_left, ph, n;
		strides = '{14'd257, 14'd8192, 14'd1000, 14'd2, 14'd0, 14'h3FFF};
		psizes = '{14'd33, 14'd257, 14'd129, 14'd3, 14'd0, 14'd65};
		strides[4] = 14'($urandom_range(0, 16383));
		psizes[4] = 14'($urandom_range(0, 511));
		burst_left = 0;
		for (ph = 0; ph < 6; ph++) begin
			set_config(strides[ph], psizes[ph]);
			for (n = 0; n < 30; n++) begin
				if (burst_left == 0) begin
					pause_sender($urandom_range(1, 8));
					burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
				end
				burst_left--;
				send_fan(random_fan());
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cells();
		test_config_extremes();
		test_random_fans();
		wait_drain();
		if (mismatches == 0)
			$display("[geomip_fan_index_generator_core] OK");
		else
			$display("[geomip_fan_index_generator_core] ERROR");
		$finish;
	end

	// Hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("[geomip_fan_index_generator_core] ERROR");
		$finish;
	end

endmodule
